[sv/pct_pkg.sv]
// Package for the per-source connection throttle: entry layout, queue item,
// and the control structs passed between the front and back parts. No dependencies.
`timescale 1ns / 1ps

package pct_pkg;

	localparam int NUM_SETS  = 256;
	localparam int NUM_WAYS  = 4;
	localparam int SET_BITS  = $clog2(NUM_SETS);
	localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ADDR_W    = 32;
	localparam int TIME_W    = 32;
	localparam int WINDOW_W  = 16;
	localparam int COUNT_W   = 8;
	localparam int PHASE_W   = 2;
	localparam int EVENT_W   = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd15;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd10;

	localparam logic [PHASE_W-1:0] PH_COUNTING = 2'd0;
	localparam logic [PHASE_W-1:0] PH_HITLIMIT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_WARNED   = 2'd2;

	localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
	localparam logic [EVENT_W-1:0] EV_THROTTLE = 2'd1;
	localparam logic [EVENT_W-1:0] EV_RESET    = 2'd2;

	localparam logic MODE_CONNECT    = 1'b0;
	localparam logic MODE_DISCONNECT = 1'b1;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  addr;
		logic [TIME_W-1:0]  seen;
		logic [COUNT_W-1:0] count;
		logic [PHASE_W-1:0] phase;
	} way_t;

	typedef way_t [NUM_WAYS-1:0] row_t;

	typedef struct packed {
		logic                mode;
		logic [ADDR_W-1:0]   addr;
		logic [TIME_W-1:0]   now;
		logic [SET_BITS-1:0] set;
	} item_t;

	// Front to back: head of the queue.
	typedef struct packed {
		logic  valid;
		item_t item;
	} fb_t;

	// Back to front: pop strobe and end of the clearing pass.
	typedef struct packed {
		logic pop;
		logic clear_done;
	} bf_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] window;
		logic [COUNT_W-1:0]  limit;
	} cfg_t;

endpackage

[sv/pct_if.sv]
// Request and result channel interfaces of the connection throttle.
// Depends on pct_pkg.
`timescale 1ns / 1ps

interface pct_req_if import pct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] source_addr;
	logic [TIME_W-1:0] now_seconds;

	modport source(output valid, mode, source_addr, now_seconds, input ready);
	modport sink(input valid, mode, source_addr, now_seconds, output ready);
endinterface

interface pct_rsp_if import pct_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               reject;
	logic [EVENT_W-1:0] event_res;
	logic               evicted;

	modport source(output valid, reject, event_res, evicted, input ready);
	modport sink(input valid, reject, event_res, evicted, output ready);
endinterface

[sv/pct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/pct_front.sv]
// Front part: accepts requests, hashes the source to a set and queues them.
// Depends on pct_pkg and pct_if.
`timescale 1ns / 1ps

module pct_front import pct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pct_req_if.sink    req,
	input  bf_t        bf,
	output fb_t        fb
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	item_t            new_item;

	assign req.ready = (count_q != CNT_W'(QUEUE_DEPTH)) && bf.clear_done;
	assign push      = req.valid && req.ready;

	always_comb begin
		new_item.mode = req.mode;
		new_item.addr = req.source_addr;
		new_item.now  = req.now_seconds;
		new_item.set  = SET_BITS'(req.source_addr[7:0] ^ req.source_addr[15:8]
			^ req.source_addr[23:16] ^ req.source_addr[31:24]);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (bf.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(bf.pop);
		end
	end

	assign fb.valid = (count_q != '0);
	assign fb.item  = slot_q[rd_ptr_q];

endmodule

[sv/pct_back.sv]
// Back part: clears the table after reset, then does one read-modify-write
// of a set per request, with no write for source 0, and holds the result. Depends on pct_pkg, pct_if, pct_ram.
`timescale 1ns / 1ps

module pct_back import pct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fb_t        fb,
	output bf_t        bf,
	input  cfg_t       cfg,
	pct_rsp_if.source  rsp
);

	typedef enum logic [1:0] {S_CLEAR, S_ISSUE, S_EXEC} state_t;

	state_t              state_q;
	logic [SET_BITS-1:0] clr_q;
	item_t               item_q;
	logic                rsp_valid_q;
	logic                reject_q;
	logic [EVENT_W-1:0]  event_q;
	logic                evicted_q;

	row_t                rd_row;
	row_t                new_row;
	logic                ram_we;
	logic [SET_BITS-1:0] ram_waddr;
	row_t                ram_wdata;
	logic                ram_re;
	logic                out_free;
	logic                exec_go;

	logic                hit;
	logic [WAY_BITS-1:0] hit_w;
	logic [NUM_WAYS-1:0] expd;
	logic                free_found;
	logic [WAY_BITS-1:0] free_w;
	logic [WAY_BITS-1:0] old_w;
	logic [COUNT_W-1:0]  cnt_inc;
	logic                c_reject;
	logic [EVENT_W-1:0]  c_event;
	logic                c_evict;

	pct_ram #(.WIDTH($bits(row_t)), .DEPTH(NUM_SETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (fb.item.set),
		.rdata (rd_row)
	);

	assign out_free      = !rsp_valid_q || rsp.ready;
	assign exec_go       = (state_q == S_EXEC) && out_free;
	assign ram_re        = (state_q == S_ISSUE) && fb.valid;
	assign bf.pop        = ram_re;
	assign bf.clear_done = (state_q != S_CLEAR);

	assign ram_we    = (state_q == S_CLEAR) || (exec_go && (item_q.addr != '0));
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : item_q.set;
	assign ram_wdata = (state_q == S_CLEAR) ? row_t'('0) : new_row;

	always_comb begin
		hit        = 1'b0;
		hit_w      = '0;
		free_found = 1'b0;
		free_w     = '0;
		old_w      = '0;
		c_reject   = 1'b0;
		c_event    = EV_NONE;
		c_evict    = 1'b0;
		cnt_inc    = '0;
		new_row    = rd_row;
		for (int w = 0; w < NUM_WAYS; w++) begin
			expd[w] = ({1'b0, rd_row[w].seen} + (TIME_W + 1)'(cfg.window))
				< {1'b0, item_q.now};
			if (rd_row[w].valid && (rd_row[w].addr == item_q.addr)) begin
				hit   = 1'b1;
				hit_w = WAY_BITS'(w);
			end
		end
		if (item_q.mode == MODE_DISCONNECT) begin
			if (hit && (rd_row[hit_w].phase == PH_COUNTING)
				&& (rd_row[hit_w].count > COUNT_W'(1))) begin
				new_row[hit_w].count = rd_row[hit_w].count - 1'b1;
			end
		end else begin
			// Free expired entries other than the match.
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (rd_row[w].valid && !(hit && (hit_w == WAY_BITS'(w))) && expd[w]) begin
					new_row[w].valid = 1'b0;
				end
			end
			if (hit) begin
				if (!expd[hit_w]) begin
					unique case (rd_row[hit_w].phase)
						PH_COUNTING: begin
							cnt_inc = (rd_row[hit_w].count != COUNT_MAX)
								? rd_row[hit_w].count + 1'b1 : rd_row[hit_w].count;
							new_row[hit_w].count = cnt_inc;
							if (cnt_inc == cfg.limit) begin
								new_row[hit_w].phase = PH_HITLIMIT;
							end
						end
						PH_HITLIMIT: begin
							new_row[hit_w].phase = PH_WARNED;
							c_reject = 1'b1;
							c_event  = EV_THROTTLE;
						end
						default: begin
						end
					endcase
				end else begin
					if (rd_row[hit_w].phase >= PH_WARNED) begin
						c_event = EV_RESET;
					end
					new_row[hit_w].count = COUNT_W'(1);
					new_row[hit_w].phase = PH_COUNTING;
				end
				new_row[hit_w].seen = item_q.now;
			end else begin
				for (int w = NUM_WAYS - 1; w >= 0; w--) begin
					if (!new_row[w].valid) begin
						free_found = 1'b1;
						free_w     = WAY_BITS'(w);
					end
				end
				for (int w = 1; w < NUM_WAYS; w++) begin
					if (rd_row[w].seen < rd_row[old_w].seen) begin
						old_w = WAY_BITS'(w);
					end
				end
				if (!free_found) begin
					free_w  = old_w;
					c_evict = 1'b1;
				end
				new_row[free_w].valid = 1'b1;
				new_row[free_w].addr  = item_q.addr;
				new_row[free_w].seen  = item_q.now;
				new_row[free_w].count = COUNT_W'(1);
				new_row[free_w].phase = PH_COUNTING;
			end
		end
		if (item_q.addr == '0) begin
			c_reject = 1'b0;
			c_event  = EV_NONE;
			c_evict  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			item_q <= fb.item;
		end
		if (exec_go) begin
			reject_q  <= c_reject;
			event_q   <= c_event;
			evicted_q <= c_evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_BITS'(NUM_SETS - 1)) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (fb.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_ISSUE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.reject    = reject_q;
	assign rsp.event_res = event_q;
	assign rsp.evicted   = evicted_q;

endmodule

[sv/per_source_connection_throttle.sv]
// Top level of the per-source connection throttle: APB registers and the
// front and back parts. Depends on pct_pkg, pct_if, pct_front, pct_back.
`timescale 1ns / 1ps

// Each request names a connect or a disconnect of an IPv4 source and gives
// exactly one result: reject, an event code and an eviction flag. Sources are
// kept in a table of 256 sets by four ways, the set chosen by the XOR of the
// four address bytes, and the whole set sits in one memory row. The back part
// reads that row in its issue state and writes it back in its exec state,
// once the result register is free, while it registers the result; no write
// is made for source address zero. It takes the next request only after that.
// A two-deep request queue in front and a result register at the back let
// either side stall without holding up the other. After reset the table is
// cleared one row a cycle; during that pass no request is taken, while
// register writes are. Registers: window_seconds at byte address 0 and
// connect_limit at byte address 4; the decode looks at paddr[2] only.
module per_source_connection_throttle import pct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pct_req_if.sink     req,
	pct_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg_q;
	fb_t  fb;
	bf_t  bf;

	assign pready = 1'b1;

	// A register write lands on the access cycle of the APB transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window <= WINDOW_RESET;
			cfg_q.limit  <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_WINDOW: cfg_q.window <= pwdata[WINDOW_W-1:0];
				REG_LIMIT:  cfg_q.limit  <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW: prdata = {{(32 - WINDOW_W){1'b0}}, cfg_q.window};
			REG_LIMIT:  prdata = {{(32 - COUNT_W){1'b0}}, cfg_q.limit};
			default:    prdata = '0;
		endcase
	end

	// The front part hashes and queues each request; the back part owns the table.
	pct_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.bf     (bf),
		.fb     (fb)
	);

	pct_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fb     (fb),
		.bf     (bf),
		.cfg    (cfg_q),
		.rsp    (rsp)
	);

endmodule

[sv/pct_checker.sv]
// Port-level checker for the connection throttle and its bind to the top level.
// Depends on pct_pkg.
`timescale 1ns / 1ps

module pct_checker import pct_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_reject,
	input logic [EVENT_W-1:0] rsp_event,
	input logic               rsp_evicted,
	input logic               pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_reject_event: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_reject == (rsp_event == EV_THROTTLE)))
		else $error("reject and throttle event disagree");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_event != 2'd3))
		else $error("unused event code");

	a_reject_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_reject |-> !rsp_evicted)
		else $error("rejected request evicted an entry");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind per_source_connection_throttle pct_checker u_pct_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_reject  (rsp.reject),
	.rsp_event   (rsp.event_res),
	.rsp_evicted (rsp.evicted),
	.pready      (pready)
);
